/* hw/rtl/drbt_pkg.sv */
`timescale 1ns / 1ps

package drbt_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] heading_cdeg;
        logic [6:0]  crumb_index;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x_mm;
        logic signed [31:0] pos_y_mm;
        logic [7:0]         crumb_total;
        logic               crumb_saved;
        logic               crumb_valid;
        logic signed [31:0] crumb_x_mm;
        logic signed [31:0] crumb_y_mm;
        logic [15:0]        crumb_heading_cdeg;
        logic [31:0]        home_distance_mm;
        logic [15:0]        home_bearing_cdeg;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG_LO,
        ST_ANG_HI,
        ST_ROT_SET,
        ST_ROT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_POS,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_D,
        ST_DECIDE,
        ST_RD_WAIT,
        ST_RD_DATA,
        ST_VEC_SET,
        ST_VEC,
        ST_MD_LO,
        ST_MD_HI,
        ST_BEAR,
        ST_FINISH
    } t_state;

    localparam logic [1:0] REQ_STEP  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam logic [1:0] CFG_STEP_LEN = 2'd0;
    localparam logic [1:0] CFG_MIN_DIST = 2'd1;
    localparam logic [1:0] CFG_MIN_HEAD = 2'd2;

    localparam logic [11:0] RST_STEP_LEN = 12'd700;
    localparam logic [19:0] RST_MIN_DIST = 20'd5000;
    localparam logic [14:0] RST_MIN_HEAD = 15'd3000;

    localparam logic [15:0] TURN_CDEG = 16'd36000;
    localparam logic [15:0] HALF_CDEG = 16'd18000;
    // angle = floor(h * 2^32 / 36000) = (h * 8006399337548) >> 26, exact for
    // h < 36000; the reciprocal is split at bit 21 for the shared multiplier
    localparam logic [20:0] ANG_RECIP_LO = 21'd1483852;
    localparam logic [21:0] ANG_RECIP_HI = 22'd3817748;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [19:0]        DIST_SCALE  = 20'd636751;
    localparam logic [19:0]        BEAR_SCALE  = 20'd36000;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

/* hw/rtl/drbt_ram.sv */
`timescale 1ns / 1ps

module drbt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/dead_reckoning_breadcrumb_tracker_unit.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                 word
// in        input      i_in_valid / o_in_stall   drbt_pkg::t_in_word
// out       output     o_out_valid / i_out_stall drbt_pkg::t_out_word
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Steps convert, rotate, move and decide on a save, reads fetch a crumb, and
// then every word runs the home vector. The heading to binary angle conversion
// is a reciprocal multiply in two passes, then the two CORDIC loops run one
// micro-rotation a cycle on one add/shift unit; a single shared 20x35
// multiplier serves the angle, step scaling, squared distances and scaling of
// distance and bearing. Input is stalled while a word is at work; the next word
// is taken as soon as the result sits in the output register, even if the
// output side stalls. Reset is synchronous; no clearing pass.

module dead_reckoning_breadcrumb_tracker_unit #(
    parameter int CRUMB_DEPTH  = 128,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  drbt_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output drbt_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [19:0]          i_cfg_data
);

    localparam int AW = (CRUMB_DEPTH > 1) ? $clog2(CRUMB_DEPTH) : 1;
    localparam int CW = $clog2(CRUMB_DEPTH + 1);
    localparam logic [4:0] ITER_LAST = 5'(CORDIC_STEPS - 1);

    drbt_pkg::t_state r_state, n_state;

    // configuration
    logic [11:0] r_step_len;
    logic [19:0] r_min_dist;
    logic [14:0] r_min_head;

    // track state
    logic signed [31:0] r_px, r_py, r_anx, r_any;
    logic [15:0]        r_prev_h;
    logic [CW-1:0]      r_count;

    // per-word working registers
    logic [1:0]         r_req;
    logic [15:0]        r_h;
    logic [6:0]         r_idx;
    logic [4:0]         r_iter;
    logic               r_flip;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [32:0] r_ex;
    logic               r_big;
    logic [40:0]        r_sx, r_s2;
    logic signed [49:0] r_u, r_v;
    logic [31:0]        r_bz;
    logic [41:0]        r_plo;
    logic [31:0]        r_dist;
    logic               r_saved, r_cvalid;
    logic signed [31:0] r_cx, r_cy;
    logic [15:0]        r_ch;

    // shared multiplier
    logic [19:0]        w_ma;
    logic signed [34:0] w_mb;
    logic               w_men;
    logic signed [55:0] r_prod;

    // output register
    drbt_pkg::t_out_word r_out;
    logic                r_out_valid;

    logic              w_accept, w_out_take, w_we;
    logic [79:0]       w_rdata;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ---------------- combinational helpers ----------------
    logic [15:0] w_hin;
    assign w_hin = (i_in_word.heading_cdeg >= drbt_pkg::TURN_CDEG) ?
                   (i_in_word.heading_cdeg - drbt_pkg::TURN_CDEG) : i_in_word.heading_cdeg;

    // binary angle: high partial product in r_prod, low one in r_plo
    logic [63:0] w_asum;
    logic [31:0] w_aq;
    assign w_asum = ({22'd0, r_prod[41:0]} << 21) + {22'd0, r_plo};
    assign w_aq   = w_asum[57:26];

    // rotation setup: fold into right half-plane
    logic        w_flip;
    logic [31:0] w_ang;
    assign w_flip = w_aq[31] ^ w_aq[30];
    assign w_ang  = w_flip ? (w_aq ^ 32'h8000_0000) : w_aq;

    logic signed [33:0] w_atan;
    assign w_atan = $signed({2'b00, drbt_pkg::ATAN_TAB[r_iter]});

    logic signed [33:0] w_cs, w_sn;
    assign w_cs = r_flip ? -r_x : r_x;
    assign w_sn = r_flip ? -r_y : r_y;

    // rounded displacement from product
    logic signed [55:0] w_rnd;
    logic signed [32:0] w_disp;
    assign w_rnd  = (r_prod + 56'sd536870912) >>> 30;
    assign w_disp = w_rnd[32:0];

    // saturating position adds
    logic signed [32:0] w_sumx, w_sumy;
    logic signed [31:0] w_npx, w_npy;
    assign w_sumx = {r_px[31], r_px} + r_ex;
    assign w_sumy = {r_py[31], r_py} + w_disp;
    assign w_npx = (w_sumx[32] != w_sumx[31]) ?
                   (w_sumx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_sumx[31:0];
    assign w_npy = (w_sumy[32] != w_sumy[31]) ?
                   (w_sumy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_sumy[31:0];

    // travel since anchor
    logic signed [32:0] w_dx, w_dy;
    logic [32:0]        w_ax, w_ay;
    assign w_dx = {r_px[31], r_px} - {r_anx[31], r_anx};
    assign w_dy = {r_py[31], r_py} - {r_any[31], r_any};
    assign w_ax = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ay = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);

    // wrapped heading change
    logic [15:0] w_dh_raw, w_dh;
    assign w_dh_raw = (r_h >= r_prev_h) ? (r_h - r_prev_h) : (r_prev_h - r_h);
    assign w_dh     = (w_dh_raw > drbt_pkg::HALF_CDEG) ?
                      (drbt_pkg::TURN_CDEG - w_dh_raw) : w_dh_raw;

    logic w_room, w_save;
    assign w_room = (32'(r_count) < CRUMB_DEPTH);
    assign w_save = w_room && (r_big || (r_s2 >= r_prod[40:0]) ||
                               (w_dh >= {1'b0, r_min_head}));

    // home vector start
    logic signed [49:0] w_hv, w_hu;
    assign w_hv = 50'sd0 - ($signed({{18{r_px[31]}}, r_px}) <<< 16);
    assign w_hu = 50'sd0 - ($signed({{18{r_py[31]}}, r_py}) <<< 16);

    // distance scaling
    logic [49:0] w_uc;
    logic [41:0] w_us;
    assign w_uc = r_u[49] ? 50'd0 : r_u;
    assign w_us = w_uc[49:8];

    logic [63:0] w_dsum;
    logic [35:0] w_dq;
    assign w_dsum = ({22'd0, r_prod[41:0]} << 21) + {22'd0, r_plo} + 64'd134217728;
    assign w_dq   = w_dsum[63:28];

    logic [48:0] w_bsum;
    logic [16:0] w_bq;
    logic [15:0] w_bear;
    assign w_bsum = {1'b0, r_prod[47:0]} + 49'd2147483648;
    assign w_bq   = w_bsum[48:32];
    assign w_bear = (w_bq >= {1'b0, drbt_pkg::TURN_CDEG}) ? 16'd0 : w_bq[15:0];

    // read result
    logic w_rd_ok;
    assign w_rd_ok = (32'(r_idx) < 32'(r_count)) && (32'(r_idx) < CRUMB_DEPTH);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            drbt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_word.req_type)
                        drbt_pkg::REQ_STEP: n_state = drbt_pkg::ST_ANG_LO;
                        drbt_pkg::REQ_READ: n_state = drbt_pkg::ST_RD_WAIT;
                        default:            n_state = drbt_pkg::ST_VEC_SET;
                    endcase
                end
            end
            drbt_pkg::ST_ANG_LO:  n_state = drbt_pkg::ST_ANG_HI;
            drbt_pkg::ST_ANG_HI:  n_state = drbt_pkg::ST_ROT_SET;
            drbt_pkg::ST_ROT_SET: n_state = drbt_pkg::ST_ROT;
            drbt_pkg::ST_ROT: begin
                if (r_iter == ITER_LAST) n_state = drbt_pkg::ST_MUL_X;
            end
            drbt_pkg::ST_MUL_X:   n_state = drbt_pkg::ST_MUL_Y;
            drbt_pkg::ST_MUL_Y:   n_state = drbt_pkg::ST_POS;
            drbt_pkg::ST_POS:     n_state = drbt_pkg::ST_SQ_X;
            drbt_pkg::ST_SQ_X:    n_state = drbt_pkg::ST_SQ_Y;
            drbt_pkg::ST_SQ_Y:    n_state = drbt_pkg::ST_SQ_D;
            drbt_pkg::ST_SQ_D:    n_state = drbt_pkg::ST_DECIDE;
            drbt_pkg::ST_DECIDE:  n_state = drbt_pkg::ST_VEC_SET;
            drbt_pkg::ST_RD_WAIT: n_state = drbt_pkg::ST_RD_DATA;
            drbt_pkg::ST_RD_DATA: n_state = drbt_pkg::ST_VEC_SET;
            drbt_pkg::ST_VEC_SET: n_state = drbt_pkg::ST_VEC;
            drbt_pkg::ST_VEC: begin
                if (r_iter == ITER_LAST) n_state = drbt_pkg::ST_MD_LO;
            end
            drbt_pkg::ST_MD_LO:   n_state = drbt_pkg::ST_MD_HI;
            drbt_pkg::ST_MD_HI:   n_state = drbt_pkg::ST_BEAR;
            drbt_pkg::ST_BEAR:    n_state = drbt_pkg::ST_FINISH;
            drbt_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) n_state = drbt_pkg::ST_IDLE;
            end
            default: n_state = drbt_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_in_stall = (r_state != drbt_pkg::ST_IDLE);
        w_we  = (r_state == drbt_pkg::ST_DECIDE) && w_save;
        w_men = 1'b1;
        w_ma  = {8'd0, r_step_len};
        w_mb  = 35'(w_sn);
        case (r_state)
            drbt_pkg::ST_ANG_LO: begin
                w_ma = {4'd0, r_h};
                w_mb = $signed({14'd0, drbt_pkg::ANG_RECIP_LO});
            end
            drbt_pkg::ST_ANG_HI: begin
                w_ma = {4'd0, r_h};
                w_mb = $signed({13'd0, drbt_pkg::ANG_RECIP_HI});
            end
            drbt_pkg::ST_MUL_X: begin
                w_ma = {8'd0, r_step_len};
                w_mb = 35'(w_sn);
            end
            drbt_pkg::ST_MUL_Y: begin
                w_ma = {8'd0, r_step_len};
                w_mb = 35'(w_cs);
            end
            drbt_pkg::ST_SQ_X: begin
                w_ma = w_ax[19:0];
                w_mb = $signed({15'd0, w_ax[19:0]});
            end
            drbt_pkg::ST_SQ_Y: begin
                w_ma = w_ay[19:0];
                w_mb = $signed({15'd0, w_ay[19:0]});
            end
            drbt_pkg::ST_SQ_D: begin
                w_ma = r_min_dist;
                w_mb = $signed({15'd0, r_min_dist});
            end
            drbt_pkg::ST_MD_LO: begin
                w_ma = drbt_pkg::DIST_SCALE;
                w_mb = $signed({14'd0, w_us[20:0]});
            end
            drbt_pkg::ST_MD_HI: begin
                w_ma = drbt_pkg::DIST_SCALE;
                w_mb = $signed({14'd0, w_us[41:21]});
            end
            drbt_pkg::ST_BEAR: begin
                w_ma = drbt_pkg::BEAR_SCALE;
                w_mb = $signed({3'd0, r_bz});
            end
            default: w_men = 1'b0;
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        if (w_men) begin
            r_prod <= $signed({1'b0, w_ma}) * w_mb;
        end
    end

    drbt_ram #(
        .WIDTH (80),
        .DEPTH (CRUMB_DEPTH)
    ) u_crumbs (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_px, r_py, r_h}),
        .i_raddr (AW'(r_idx)),
        .o_rdata (w_rdata)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drbt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_step_len  <= drbt_pkg::RST_STEP_LEN;
            r_min_dist  <= drbt_pkg::RST_MIN_DIST;
            r_min_head  <= drbt_pkg::RST_MIN_HEAD;
            r_px        <= '0;
            r_py        <= '0;
            r_anx       <= '0;
            r_any       <= '0;
            r_prev_h    <= '0;
            r_count     <= CW'(1);
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    drbt_pkg::CFG_STEP_LEN: r_step_len <= i_cfg_data[11:0];
                    drbt_pkg::CFG_MIN_DIST: r_min_dist <= i_cfg_data;
                    drbt_pkg::CFG_MIN_HEAD: r_min_head <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            if (w_accept && (i_in_word.req_type == drbt_pkg::REQ_CLEAR)) begin
                r_px    <= '0;
                r_py    <= '0;
                r_anx   <= '0;
                r_any   <= '0;
                r_count <= CW'(1);
            end

            if (r_state == drbt_pkg::ST_POS) begin
                r_px <= w_npx;
                r_py <= w_npy;
            end

            if (r_state == drbt_pkg::ST_DECIDE) begin
                r_prev_h <= r_h;
                if (w_save) begin
                    r_count <= r_count + CW'(1);
                    r_anx   <= r_px;
                    r_any   <= r_py;
                end
            end

            if (r_state == drbt_pkg::ST_FINISH && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            drbt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_req    <= i_in_word.req_type;
                    r_h      <= w_hin;
                    r_idx    <= i_in_word.crumb_index;
                    r_saved  <= 1'b0;
                    r_cvalid <= 1'b0;
                    r_cx     <= '0;
                    r_cy     <= '0;
                    r_ch     <= '0;
                    r_iter   <= '0;
                end
            end
            drbt_pkg::ST_ANG_HI: begin
                r_plo <= r_prod[41:0];
            end
            drbt_pkg::ST_ROT_SET: begin
                r_flip <= w_flip;
                r_x    <= drbt_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= 34'($signed(w_ang));
                r_iter <= '0;
            end
            drbt_pkg::ST_ROT: begin
                if (!r_z[33]) begin
                    r_x <= r_x - (r_y >>> r_iter);
                    r_y <= r_y + (r_x >>> r_iter);
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + (r_y >>> r_iter);
                    r_y <= r_y - (r_x >>> r_iter);
                    r_z <= r_z + w_atan;
                end
                r_iter <= r_iter + 5'd1;
            end
            drbt_pkg::ST_MUL_Y: begin
                r_ex <= w_disp;
            end
            drbt_pkg::ST_SQ_X: begin
                // beyond 2^20 either square already tops any threshold
                r_big <= (w_ax[32:20] != '0) || (w_ay[32:20] != '0);
            end
            drbt_pkg::ST_SQ_Y: begin
                r_sx <= r_prod[40:0];
            end
            drbt_pkg::ST_SQ_D: begin
                r_s2 <= r_sx + r_prod[40:0];
            end
            drbt_pkg::ST_DECIDE: begin
                r_saved <= w_save;
            end
            drbt_pkg::ST_RD_DATA: begin
                if (w_rd_ok) begin
                    r_cvalid <= 1'b1;
                    // crumb 0 is always the origin
                    if (r_idx != 7'd0) begin
                        r_cx <= w_rdata[79:48];
                        r_cy <= w_rdata[47:16];
                        r_ch <= w_rdata[15:0];
                    end
                end
            end
            drbt_pkg::ST_VEC_SET: begin
                r_iter <= '0;
                if (w_hu[49]) begin
                    r_u  <= -w_hu;
                    r_v  <= -w_hv;
                    r_bz <= 32'h8000_0000;
                end else begin
                    r_u  <= w_hu;
                    r_v  <= w_hv;
                    r_bz <= 32'd0;
                end
            end
            drbt_pkg::ST_VEC: begin
                if (!r_v[49]) begin
                    r_u  <= r_u + (r_v >>> r_iter);
                    r_v  <= r_v - (r_u >>> r_iter);
                    r_bz <= r_bz + drbt_pkg::ATAN_TAB[r_iter];
                end else begin
                    r_u  <= r_u - (r_v >>> r_iter);
                    r_v  <= r_v + (r_u >>> r_iter);
                    r_bz <= r_bz - drbt_pkg::ATAN_TAB[r_iter];
                end
                r_iter <= r_iter + 5'd1;
            end
            drbt_pkg::ST_MD_HI: begin
                r_plo <= r_prod[41:0];
            end
            drbt_pkg::ST_BEAR: begin
                r_dist <= (w_dq[35:32] != 4'd0) ? 32'hFFFF_FFFF : w_dq[31:0];
            end
            drbt_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out.pos_x_mm           <= r_px;
                    r_out.pos_y_mm           <= r_py;
                    r_out.crumb_total        <= 8'(r_count);
                    r_out.crumb_saved        <= r_saved;
                    r_out.crumb_valid        <= r_cvalid;
                    r_out.crumb_x_mm         <= r_cx;
                    r_out.crumb_y_mm         <= r_cy;
                    r_out.crumb_heading_cdeg <= r_ch;
                    r_out.home_distance_mm   <= r_dist;
                    r_out.home_bearing_cdeg  <= w_bear;
                end
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) >= 1) && (32'(r_count) <= CRUMB_DEPTH))
        else $error("crumb count out of range");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (32'(r_count) < CRUMB_DEPTH))
        else $error("crumb write with full store");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != drbt_pkg::ST_IDLE))
        else $error("sequencer idle after accepting a word");

    a_req_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drbt_pkg::ST_ANG_LO) |-> (r_req == drbt_pkg::REQ_STEP))
        else $error("angle conversion running for a non-step word");

endmodule

/* dv/tb_dead_reckoning_breadcrumb_tracker_unit.sv */
`timescale 1ns / 1ps

// Tracker scoreboard: mirrors the dead-reckoning state and holds the words
// the block is expected to return, oldest first.
class drbt_track_board;

    localparam int DEPTH = 128;
    localparam int NSTEP = 16;

    logic [11:0] step_len;
    logic [19:0] min_dist;
    logic [14:0] min_head;
    logic signed [31:0] pos_x, pos_y, anc_x, anc_y;
    logic [15:0] prev_head;
    int unsigned n_crumbs;
    logic signed [31:0] store_x [DEPTH];
    logic signed [31:0] store_y [DEPTH];
    logic [15:0] store_h [DEPTH];
    drbt_pkg::t_out_word pending [$];
    int n_bad;

    function new();
        step_len  = 12'd700;
        min_dist  = 20'd5000;
        min_head  = 15'd3000;
        prev_head = '0;
        n_bad     = 0;
        wipe_track();
    endfunction

    function void wipe_track();
        pos_x = 0; pos_y = 0; anc_x = 0; anc_y = 0;
        store_x[0] = 0; store_y[0] = 0; store_h[0] = 0;
        n_crumbs = 1;
    endfunction

    function void set_reg(logic [1:0] idx, logic [19:0] val);
        case (idx)
            drbt_pkg::CFG_STEP_LEN: step_len = val[11:0];
            drbt_pkg::CFG_MIN_DIST: min_dist = val;
            drbt_pkg::CFG_MIN_HEAD: min_head = val[14:0];
            default: ;
        endcase
    endfunction

    // floor arithmetic shift on 64-bit signed
    function longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q30 cosine (north) and sine (east) of a heading by CORDIC rotation
    function void heading_trig(int unsigned h, output longint cs, output longint sn);
        logic [31:0] ang;
        logic flip;
        longint x, y, z, dx, dy;
        ang  = 32'(({32'(h), 32'd0}) / 64'd36000);
        flip = ang[31] ^ ang[30];
        x = 652032874; y = 0;
        if (flip) ang = ang - 32'h8000_0000;
        z = longint'($signed(ang));
        for (int i = 0; i < NSTEP; i++) begin
            dx = asr(y, i); dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(drbt_pkg::ATAN_TAB[i]);
            end else begin
                x += dx; y -= dy; z += longint'(drbt_pkg::ATAN_TAB[i]);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // distance and bearing back to crumb 0
    function void homing(output logic [31:0] home_mm, output logic [15:0] bear);
        longint v, u, du, dv;
        logic [31:0] z;
        logic [63:0] d, b;
        v = (longint'(store_x[0]) - longint'(pos_x)) * 65536;
        u = (longint'(store_y[0]) - longint'(pos_y)) * 65536;
        z = 0;
        if (u < 0) begin
            u = -u; v = -v; z = 32'h8000_0000;
        end
        for (int i = 0; i < NSTEP; i++) begin
            du = asr(v, i); dv = asr(u, i);
            if (v >= 0) begin
                u += du; v -= dv; z += drbt_pkg::ATAN_TAB[i];
            end else begin
                u -= du; v += dv; z -= drbt_pkg::ATAN_TAB[i];
            end
        end
        if (u < 0) u = 0;
        d = ((64'(u) >> 8) * 64'd636751 + 64'd134217728) >> 28;
        home_mm = d > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : d[31:0];
        b = (64'(z) * 64'd36000 + 64'h8000_0000) >> 32;
        bear = b >= 64'd36000 ? 16'd0 : b[15:0];
    endfunction

    function void note_word(drbt_pkg::t_in_word w);
        drbt_pkg::t_out_word r;
        int unsigned h, dh;
        longint cs, sn, ex, ey;
        logic [63:0] sx, sy, s2, md2;
        r = '0;
        h = int'(w.heading_cdeg) % 36000;
        case (w.req_type)
            drbt_pkg::REQ_STEP: begin
                heading_trig(h, cs, sn);
                ex = asr(longint'(step_len) * sn + (64'sd1 << 29), 30);
                ey = asr(longint'(step_len) * cs + (64'sd1 << 29), 30);
                pos_x = 32'(sat(longint'(pos_x) + ex));
                pos_y = 32'(sat(longint'(pos_y) + ey));
                ex = longint'(pos_x) - longint'(anc_x);
                ey = longint'(pos_y) - longint'(anc_y);
                sx = ex < 0 ? -ex : ex;
                sy = ey < 0 ? -ey : ey;
                sx = sx * sx; sy = sy * sy;
                s2 = sx + sy;
                if (s2 < sx) s2 = '1;
                md2 = 64'(min_dist) * 64'(min_dist);
                dh = h >= prev_head ? h - prev_head : prev_head - h;
                if (dh > 18000) dh = 36000 - dh;
                if ((s2 >= md2 || dh >= min_head) && n_crumbs < DEPTH) begin
                    store_x[n_crumbs] = pos_x;
                    store_y[n_crumbs] = pos_y;
                    store_h[n_crumbs] = 16'(h);
                    n_crumbs++;
                    anc_x = pos_x; anc_y = pos_y;
                    r.crumb_saved = 1'b1;
                end
                prev_head = 16'(h);
            end
            drbt_pkg::REQ_CLEAR: wipe_track();
            drbt_pkg::REQ_READ: begin
                if (w.crumb_index < n_crumbs) begin
                    r.crumb_valid        = 1'b1;
                    r.crumb_x_mm         = store_x[w.crumb_index];
                    r.crumb_y_mm         = store_y[w.crumb_index];
                    r.crumb_heading_cdeg = store_h[w.crumb_index];
                end
            end
            default: ;
        endcase
        homing(r.home_distance_mm, r.home_bearing_cdeg);
        r.pos_x_mm    = pos_x;
        r.pos_y_mm    = pos_y;
        r.crumb_total = 8'(n_crumbs);
        pending.push_back(r);
    endfunction

    function void check_word(drbt_pkg::t_out_word got);
        drbt_pkg::t_out_word want;
        if (pending.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) $display("unexpected out word %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("mismatch: want pos %0d,%0d tot %0d sv %b vl %b c %0d,%0d,%0d d %0d b %0d",
                    want.pos_x_mm, want.pos_y_mm, want.crumb_total, want.crumb_saved,
                    want.crumb_valid, want.crumb_x_mm, want.crumb_y_mm,
                    want.crumb_heading_cdeg, want.home_distance_mm, want.home_bearing_cdeg);
                $display("          got  pos %0d,%0d tot %0d sv %b vl %b c %0d,%0d,%0d d %0d b %0d",
                    got.pos_x_mm, got.pos_y_mm, got.crumb_total, got.crumb_saved,
                    got.crumb_valid, got.crumb_x_mm, got.crumb_y_mm,
                    got.crumb_heading_cdeg, got.home_distance_mm, got.home_bearing_cdeg);
            end
        end
    endfunction
endclass

module tb_dead_reckoning_breadcrumb_tracker_unit;

    localparam int WDOG_LIMIT = 20000;   // idle cycles before the watchdog ends the run
    localparam int SETTLE     = 200;     // past the longest item latency

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    drbt_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    drbt_pkg::t_out_word o_out_word;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [19:0]         i_cfg_data = '0;

    drbt_track_board board;
    int  idle_cycles = 0;
    bit  hold_out = 1'b0;     // receiver long hold-off request
    bit  random_stall = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    dead_reckoning_breadcrumb_tracker_unit i_dut (.*);

    // short gaps mostly, a long one now and then
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // output side: random stall, collects words on accept
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_word(o_out_word);
        end
    end

    initial begin : out_stall_gen
        int g;
        @(posedge i_clk);
        forever begin
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_out = 1'b0;
            end else if (random_stall && $urandom_range(3) == 0) begin
                g = gap_len();
                i_out_stall <= 1'b1;
                repeat (g + 1) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // watchdog: ends the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // one word into the block; the model is updated on acceptance
    task automatic send_word(logic [1:0] req, logic [15:0] head, logic [6:0] idx);
        drbt_pkg::t_in_word w;
        w.req_type     = req;
        w.heading_cdeg = head;
        w.crumb_index  = idx;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_word(w);
    endtask

    task automatic idle_in(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drains the output side, then lets the block go quiet before a write
    task automatic drain();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random stimulus: mostly steps, some reads of the live store, few clears and unused codes
    task automatic random_words(int n, bit gaps);
        int p;
        logic [15:0] h;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(99);
            h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(35999));
            if (p < 70)
                send_word(drbt_pkg::REQ_STEP, h, 7'($urandom));
            else if (p < 90)
                send_word(drbt_pkg::REQ_READ, 16'($urandom),
                          ($urandom_range(3) == 0) ? 7'($urandom)
                                                   : 7'($urandom_range(board.n_crumbs - 1)));
            else if (p < 96)
                send_word(drbt_pkg::REQ_CLEAR, 16'($urandom), 7'($urandom));
            else
                send_word(drbt_pkg::REQ_SPARE, 16'($urandom), 7'($urandom));
            if (gaps) idle_in(gap_len());
        end
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: headings at the extremes, all request codes, out-of-range
        // heading, reads in and out of range, unused code
        send_word(drbt_pkg::REQ_STEP, 16'd0, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd9000, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd18000, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd27000, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd35999, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd36000, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'hFFFF, 7'h7F);
        send_word(drbt_pkg::REQ_STEP, 16'd4500, 7'd0);
        send_word(drbt_pkg::REQ_READ, 16'd0, 7'd0);
        send_word(drbt_pkg::REQ_READ, 16'd0, 7'd1);
        send_word(drbt_pkg::REQ_READ, 16'hFFFF, 7'd127);
        send_word(drbt_pkg::REQ_SPARE, 16'hFFFF, 7'h7F);
        send_word(drbt_pkg::REQ_CLEAR, 16'd0, 7'd0);
        send_word(drbt_pkg::REQ_READ, 16'd0, 7'd0);
        send_word(drbt_pkg::REQ_READ, 16'd0, 7'd1);
        drain();

        // fill the store: zero thresholds save on every step until the store is full
        write_reg(drbt_pkg::CFG_MIN_DIST, 20'd0);
        write_reg(drbt_pkg::CFG_MIN_HEAD, 20'd0);
        write_reg(drbt_pkg::CFG_STEP_LEN, 20'd4095);
        for (int k = 0; k < 135; k++)
            send_word(drbt_pkg::REQ_STEP, 16'($urandom_range(35999)), 7'd0);
        send_word(drbt_pkg::REQ_READ, 16'd0, 7'd127);
        drain();

        // thresholds set high: saves only on large turns
        write_reg(drbt_pkg::CFG_MIN_DIST, 20'd1000000);
        write_reg(drbt_pkg::CFG_MIN_HEAD, 20'd18000);
        write_reg(drbt_pkg::CFG_STEP_LEN, 20'd0);
        send_word(drbt_pkg::REQ_CLEAR, 16'd0, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd0, 7'd0);
        send_word(drbt_pkg::REQ_STEP, 16'd18000, 7'd0);
        random_words(60, 1);
        drain();

        // reset values again, random mix with receiver hold-off
        write_reg(drbt_pkg::CFG_STEP_LEN, 20'd700);
        write_reg(drbt_pkg::CFG_MIN_DIST, 20'd5000);
        write_reg(drbt_pkg::CFG_MIN_HEAD, 20'd3000);
        hold_out = 1'b1;
        random_words(200, 1);
        drain();

        // no sender gaps and no receiver stalls; the sender pauses only after all results are back
        write_reg(drbt_pkg::CFG_STEP_LEN, 20'($urandom_range(4095)));
        write_reg(drbt_pkg::CFG_MIN_DIST, 20'($urandom_range(20000)));
        write_reg(drbt_pkg::CFG_MIN_HEAD, 20'($urandom_range(18000)));
        random_stall = 1'b0;
        random_words(150, 0);
        drain();
        random_stall = 1'b1;

        write_reg(drbt_pkg::CFG_STEP_LEN, 20'd1);
        write_reg(drbt_pkg::CFG_MIN_DIST, 20'd3);
        write_reg(drbt_pkg::CFG_MIN_HEAD, 20'd1);
        random_words(150, 1);
        drain();

        write_reg(drbt_pkg::CFG_STEP_LEN, 20'($urandom_range(4095)));
        write_reg(drbt_pkg::CFG_MIN_DIST, 20'($urandom_range(1000000)));
        write_reg(drbt_pkg::CFG_MIN_HEAD, 20'($urandom_range(18000)));
        random_words(150, 1);
        drain();

        if (board.n_bad == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
